// ----- hdl/sft_pkg.sv -----
// shared types, codes and helpers for the ipv4 subnet flag trie
// no dependencies
package sft_pkg;

  localparam int STRIDE = 8;
  localparam int WAYS = 256;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [1:0] LEVEL_LAST = 2'd3;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_LEAF  = 2'd1,
    KIND_NODE  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_LK_RD, S_LK_EV, S_CN_RD, S_CN_EV, S_POOL,
    S_WK_RD, S_WK_EV, S_FILL, S_LINK, S_CV_START, S_CV_RD, S_CV_EV, S_CV_ADV
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       clr;
    logic       walk_start;
    logic       rd_walk;
    logic       walk_adv;
    logic       need_set;
    logic       alloc;
    logic       fill;
    logic       link;
    logic       cover_start;
    logic       rd_cover;
    logic       cover_write;
    logic       push;
    logic       pop;
    logic       idx_inc;
    logic       res_load;
    logic       res_leaf;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic  is_add;
    logic  bad;
    logic  last_zero;
    logic  pool_short;
    kind_t rkind;
    logic  lvl_max;
    logic  next_last;
    logic  clr_last;
    logic  fill_last;
    logic  idx_end;
    logic  d_top;
    logic  d_deep;
    logic  out_valid;
  } stat_t;

  function automatic logic [7:0] addr_byte(input logic [31:0] a, input logic [1:0] l);
    logic [7:0] b;
    case (l)
      2'd0:    b = a[31:24];
      2'd1:    b = a[23:16];
      2'd2:    b = a[15:8];
      default: b = a[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/sft_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module sft_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end
endmodule

// ----- hdl/sft_ctrl.sv -----
// sequencer for clear, lookup, add walk, node split and subtree cover
// depends on sft_pkg
module sft_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sft_pkg::stat_t st,
  output sft_pkg::cmd_t  cmd
);
  import sft_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !st.out_valid;
        if (in_valid && !st.out_valid) begin
          cmd.latch = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.walk_start = 1'b1;
        if (!st.is_add) begin
          state_next = S_LK_RD;
        end else if (st.bad) begin
          cmd.res_load = 1'b1;
          cmd.res_status = STATUS_BAD;
          state_next = S_IDLE;
        end else if (st.last_zero) begin
          state_next = S_POOL;
        end else begin
          state_next = S_CN_RD;
        end
      end
      S_LK_RD: begin
        cmd.rd_walk = 1'b1;
        state_next = S_LK_EV;
      end
      S_LK_EV: begin
        if (st.rkind == KIND_NODE && !st.lvl_max) begin
          cmd.walk_adv = 1'b1;
          state_next = S_LK_RD;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_status = STATUS_OK;
          cmd.res_leaf = (st.rkind == KIND_LEAF);
          state_next = S_IDLE;
        end
      end
      S_CN_RD: begin
        cmd.rd_walk = 1'b1;
        state_next = S_CN_EV;
      end
      S_CN_EV: begin
        if (st.rkind == KIND_NODE) begin
          cmd.walk_adv = 1'b1;
          state_next = st.next_last ? S_POOL : S_CN_RD;
        end else begin
          cmd.need_set = 1'b1;
          state_next = S_POOL;
        end
      end
      S_POOL: begin
        if (st.pool_short) begin
          cmd.res_load = 1'b1;
          cmd.res_status = STATUS_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.walk_start = 1'b1;
          state_next = st.last_zero ? S_CV_START : S_WK_RD;
        end
      end
      S_WK_RD: begin
        cmd.rd_walk = 1'b1;
        state_next = S_WK_EV;
      end
      S_WK_EV: begin
        if (st.rkind == KIND_NODE) begin
          cmd.walk_adv = 1'b1;
          state_next = st.next_last ? S_CV_START : S_WK_RD;
        end else begin
          cmd.alloc = 1'b1;
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (st.fill_last) state_next = S_LINK;
      end
      S_LINK: begin
        cmd.link = 1'b1;
        state_next = st.next_last ? S_CV_START : S_WK_RD;
      end
      S_CV_START: begin
        cmd.cover_start = 1'b1;
        state_next = S_CV_RD;
      end
      S_CV_RD: begin
        cmd.rd_cover = 1'b1;
        state_next = S_CV_EV;
      end
      S_CV_EV: begin
        if (st.rkind == KIND_NODE) begin
          if (st.d_deep) begin
            cmd.push = 1'b1;
            state_next = S_CV_RD;
          end else begin
            state_next = S_CV_ADV;
          end
        end else if (st.rkind == KIND_EMPTY || st.rkind == KIND_LEAF) begin
          cmd.cover_write = 1'b1;
          state_next = S_CV_ADV;
        end else begin
          state_next = S_CV_ADV;
        end
      end
      S_CV_ADV: begin
        if (st.idx_end) begin
          if (st.d_top) begin
            cmd.res_load = 1'b1;
            cmd.res_status = STATUS_OK;
            state_next = S_IDLE;
          end else begin
            cmd.pop = 1'b1;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_CV_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- hdl/sft_dpath.sv -----
// datapath: item registers, walk and cover stack, node pool memory, result register
// depends on sft_pkg and sft_ram
module sft_dpath #(
  parameter int NODE_POOL = 64,
  parameter int FLAG_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  sft_pkg::cmd_t  cmd,
  output sft_pkg::stat_t st,
  input  logic           in_op,
  input  logic [31:0]    in_address,
  input  logic [5:0]     in_prefix_len,
  input  logic [31:0]    in_subnet_flags,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output logic [31:0]    out_match_flags
);
  import sft_pkg::*;

  localparam int NB = $clog2(NODE_POOL);
  localparam int NUW = $clog2(NODE_POOL + 1);
  localparam int VW = (FLAG_BITS > NB) ? FLAG_BITS : NB;
  localparam int EW = VW + 2;
  localparam int AW = NB + 8;

  logic                 op_r;
  logic [31:0]          addr_r;
  logic [5:0]           len_r;
  logic [FLAG_BITS-1:0] flags_r, flags_m;
  logic [1:0]           lvl, need, d;
  logic [NB-1:0]        cur;
  logic [NUW-1:0]       nodes_used;
  logic [7:0]           clr_cnt, fill_cnt;
  kind_t                fill_kind;
  logic [VW-1:0]        fill_val;
  logic [NB-1:0]        snode [4];
  logic [7:0]           sidx [4];
  logic [7:0]           send [4];

  logic                 ram_en, ram_we;
  logic [AW-1:0]        ram_addr;
  logic [EW-1:0]        ram_wdata, rdata;
  kind_t                rkind;
  logic [VW-1:0]        rval;
  logic [NB-1:0]        child;
  logic [5:0]           lenm1;
  logic [1:0]           last;
  logic [7:0]           pmask, wbyte, lbyte;
  logic [31:0]          leaf_flags;

  for (genvar g = 0; g < FLAG_BITS; g++) begin : g_fm
    if (g < 32) begin : g_in
      assign flags_m[g] = in_subnet_flags[g];
    end else begin : g_zero
      assign flags_m[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < 32; g++) begin : g_mf
    if (g < FLAG_BITS) begin : g_in
      assign leaf_flags[g] = rval[g];
    end else begin : g_zero
      assign leaf_flags[g] = 1'b0;
    end
  end

  assign rkind = kind_t'(rdata[1:0]);
  assign rval = rdata[EW-1:2];
  assign child = rval[NB-1:0];
  assign lenm1 = len_r - 6'd1;
  assign last = lenm1[4:3];
  assign pmask = BYTE_MASK << (3'd7 - lenm1[2:0]);
  assign wbyte = addr_byte(addr_r, lvl);
  assign lbyte = addr_byte(addr_r, last);

  always_comb begin
    st = '0;
    st.is_add = (op_r == OP_ADD);
    st.bad = (len_r == 6'd0) || (len_r > 6'd32) || (flags_r == '0);
    st.last_zero = (last == 2'd0);
    st.pool_short = ({1'b0, nodes_used} + (NUW+1)'(need)) > (NUW+1)'(NODE_POOL);
    st.rkind = rkind;
    st.lvl_max = (lvl == LEVEL_LAST);
    st.next_last = ((lvl + 2'd1) == last);
    st.clr_last = (clr_cnt == BYTE_MASK);
    st.fill_last = (fill_cnt == BYTE_MASK);
    st.idx_end = (sidx[d] == send[d]);
    st.d_top = (d == last);
    st.d_deep = (d != LEVEL_LAST);
    st.out_valid = out_valid;
  end

  // single port: one read or one write per cycle, chosen by the command
  always_comb begin
    logic [VW-1:0] v;
    v = '0;
    ram_en = 1'b0;
    ram_we = 1'b0;
    ram_addr = {cur, wbyte};
    ram_wdata = '0;
    if (cmd.clr) begin
      ram_en = 1'b1;
      ram_we = 1'b1;
      ram_addr = {NB'(0), clr_cnt};
      ram_wdata = {v, KIND_EMPTY};
    end else if (cmd.rd_walk) begin
      ram_en = 1'b1;
    end else if (cmd.fill) begin
      ram_en = 1'b1;
      ram_we = 1'b1;
      ram_addr = {nodes_used[NB-1:0], fill_cnt};
      ram_wdata = {fill_val, fill_kind};
    end else if (cmd.link) begin
      v[NB-1:0] = nodes_used[NB-1:0];
      ram_en = 1'b1;
      ram_we = 1'b1;
      ram_wdata = {v, KIND_NODE};
    end else if (cmd.rd_cover) begin
      ram_en = 1'b1;
      ram_addr = {snode[d], sidx[d]};
    end else if (cmd.cover_write) begin
      v[FLAG_BITS-1:0] = flags_r;
      if (rkind == KIND_LEAF) v = rval | v;
      ram_en = 1'b1;
      ram_we = 1'b1;
      ram_addr = {snode[d], sidx[d]};
      ram_wdata = {v, KIND_LEAF};
    end
  end

  sft_ram #(.WIDTH(EW), .DEPTH(NODE_POOL * WAYS)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= NUW'(1);
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 8'd1;
      if (cmd.link) nodes_used <= nodes_used + NUW'(1);
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_op;
      addr_r <= in_address;
      len_r <= in_prefix_len;
      flags_r <= flags_m;
    end
    if (cmd.walk_start) begin
      lvl <= 2'd0;
      cur <= '0;
      need <= 2'd0;
    end
    if (cmd.walk_adv) begin
      lvl <= lvl + 2'd1;
      cur <= child;
    end
    // a missing link here means every level down to the prefix needs a new node
    if (cmd.need_set) need <= last - lvl;
    if (cmd.alloc) begin
      fill_cnt <= '0;
      fill_kind <= (rkind == KIND_LEAF) ? KIND_LEAF : KIND_EMPTY;
      fill_val <= (rkind == KIND_LEAF) ? rval : '0;
    end
    if (cmd.fill) fill_cnt <= fill_cnt + 8'd1;
    if (cmd.link) begin
      lvl <= lvl + 2'd1;
      cur <= nodes_used[NB-1:0];
    end
    if (cmd.cover_start) begin
      d <= last;
      snode[last] <= cur;
      sidx[last] <= lbyte & pmask;
      send[last] <= lbyte | ~pmask;
    end
    if (cmd.push) begin
      d <= d + 2'd1;
      snode[d + 2'd1] <= child;
      sidx[d + 2'd1] <= 8'd0;
      send[d + 2'd1] <= BYTE_MASK;
    end
    if (cmd.pop) d <= d - 2'd1;
    if (cmd.idx_inc) sidx[d] <= sidx[d] + 8'd1;
    if (cmd.res_load) begin
      out_status <= cmd.res_status;
      out_match_flags <= cmd.res_leaf ? leaf_flags : 32'd0;
    end
  end
endmodule

// ----- hdl/ipv4_subnet_flag_trie_core.sv -----
// top level of the ipv4 subnet flag trie: stream ports around controller and datapath
// depends on sft_pkg, sft_ctrl, sft_dpath
//
// One item is handled at a time over a single-port node memory. After reset the
// root node's 256 entries are cleared, and no beat is taken until that is done.
// A lookup reads and evaluates one entry for each trie level it visits. An add
// with a prefix longer than 8 bits walks the path twice, once to count the nodes
// it needs and once to build them, fills all 256 entries of each node it has to
// create or split, and then visits every entry it covers, including entries of
// linked subtrees beneath the prefix.
// A new beat is taken once the previous result has been taken.
module ipv4_subnet_flag_trie_core #(
  parameter int NODE_POOL = 64,
  parameter int FLAG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // address[31:0], prefix_len[37:32], subnet_flags[69:38]
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[1:0], match_flags[33:2]
);
  import sft_pkg::*;

  cmd_t        cmd;
  stat_t       st;
  logic [1:0]  status;
  logic [31:0] match_flags;

  sft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sft_dpath #(.NODE_POOL(NODE_POOL), .FLAG_BITS(FLAG_BITS)) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .in_op           (s_axis_tuser),
    .in_address      (s_axis_tdata[31:0]),
    .in_prefix_len   (s_axis_tdata[37:32]),
    .in_subnet_flags (s_axis_tdata[69:38]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_status      (status),
    .out_match_flags (match_flags)
  );

  assign m_axis_tdata = {6'd0, match_flags, status};
endmodule

// ----- hdl/sft_checker.sv -----
// port-level checks for the ipv4 subnet flag trie core, bound to the top level
// depends on sft_pkg
module sft_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import sft_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("beat taken while previous item in flight");

  a_no_take_with_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result waits");

  a_err_no_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != STATUS_OK |-> m_axis_tdata[33:2] == 32'd0)
    else $error("flags returned with error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] == STATUS_OK || m_axis_tdata[1:0] == STATUS_BAD
                      || m_axis_tdata[1:0] == STATUS_FULL)
    else $error("unknown status code");
endmodule

bind ipv4_subnet_flag_trie_core sft_checker u_sft_checker (.*);
